>>> rtl/ibh_pkg.sv
// Package for the indexed binary min-heap unit: sizes, codes, entry type
// and sequencer states. No dependencies.
package ibh_pkg;
  localparam int CAPACITY  = 256;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int COUNT_W   = ADDR_W + 1;
  localparam int HANDLE_W  = 8;
  localparam int HANDLES   = 1 << HANDLE_W;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_REKEY  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [HANDLE_W-1:0]  handle;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_FETCH, S_UP, S_UP_W, S_DOWN, S_DN_L, S_DN_R,
    S_DN_CMP, S_PLACE, S_FINISH
  } state_t;
endpackage

>>> rtl/ibh_if.sv
// Valid/ready channels for requests and responses of the heap unit.
// Depends on ibh_pkg.
interface ibh_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [ibh_pkg::KEY_WIDTH-1:0] key;
  logic [ibh_pkg::HANDLE_W-1:0]  handle;
  logic [ibh_pkg::ADDR_W-1:0]    position;
  modport source (output valid, mode, key, handle, position, input ready);
  modport sink (input valid, mode, key, handle, position, output ready);
endinterface

interface ibh_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ibh_pkg::KEY_WIDTH-1:0] found_key;
  logic [ibh_pkg::HANDLE_W-1:0]  found_handle;
  logic [ibh_pkg::COUNT_W-1:0]   entry_count;
  modport source (output valid, status, found_key, found_handle, entry_count, input ready);
  modport sink (input valid, status, found_key, found_handle, entry_count, output ready);
endinterface

>>> rtl/indexed_binary_min_heap_unit.sv
// Indexed binary min-heap unit: sequencer, heap RAM and handle-to-position RAM.
// Depends on ibh_pkg, ibh_if and ibh_ram.
// Read takes its entry straight from the heap RAM; insert sifts up; remove and
// rekey sift up or down, all through the single read port of the heap RAM.
// One request at a time: the next is taken in the cycle after the response
// loads. Reset: synchronous; empties the heap and marks all handles absent at
// once.
module indexed_binary_min_heap_unit (
  input  logic clk,
  input  logic rst,
  ibh_req_if.sink   req,
  ibh_rsp_if.source rsp
);
  localparam int AW = ibh_pkg::ADDR_W;
  localparam int CW = ibh_pkg::COUNT_W;

  ibh_pkg::state_t state, state_next;

  logic [CW-1:0]                 occ;
  logic [AW-1:0]                 pos, cpos;
  ibh_pkg::entry_t               cur, child;
  logic                          moved;
  logic [1:0]                    mode_r;
  logic [ibh_pkg::KEY_WIDTH-1:0] key_r;
  logic [ibh_pkg::HANDLE_W-1:0]  h_r;
  logic [AW-1:0]                 position_r;
  logic [1:0]                    status_r;
  ibh_pkg::entry_t               found_r;
  logic [ibh_pkg::HANDLES-1:0]   present_bits;
  logic                          out_valid;
  logic                          out_load;

  logic                          heap_we;
  logic [AW-1:0]                 heap_waddr, heap_raddr;
  ibh_pkg::entry_t               heap_wdata, heap_rdata;
  logic                          slot_we;
  logic [ibh_pkg::HANDLE_W-1:0]  slot_waddr;
  logic [AW-1:0]                 slot_wdata, slot_rdata;

  logic          present;
  logic [CW-1:0] last;
  logic [AW-1:0] parent;
  logic [CW-1:0] c_left, c_right;

  assign present = present_bits[h_r] && ({1'b0, slot_rdata} < occ);
  assign last    = occ - CW'(1);
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign c_left  = {pos, 1'b1};
  assign c_right = c_left + CW'(1);

  ibh_ram #(.WIDTH($bits(ibh_pkg::entry_t)), .DEPTH(ibh_pkg::CAPACITY)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  ibh_ram #(.WIDTH(AW), .DEPTH(ibh_pkg::HANDLES)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(req.handle), .rdata(slot_rdata)
  );

  assign req.ready = (state == ibh_pkg::S_IDLE);
  assign out_load  = (state == ibh_pkg::S_FINISH) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    heap_we    = 1'b0;
    heap_waddr = pos;
    heap_wdata = cur;
    heap_raddr = pos;
    slot_we    = 1'b0;
    slot_waddr = cur.handle;
    slot_wdata = pos;
    case (state)
      ibh_pkg::S_IDLE: begin
        heap_raddr = req.position;
        if (req.valid) begin
          state_next = ibh_pkg::S_LOOK;
        end
      end
      ibh_pkg::S_LOOK: begin
        heap_raddr = slot_rdata;
        state_next = ibh_pkg::S_FINISH;
        case (mode_r)
          ibh_pkg::MODE_INSERT: begin
            if (!present && !occ[CW-1]) begin
              state_next = ibh_pkg::S_UP;
            end
          end
          ibh_pkg::MODE_REMOVE: begin
            heap_raddr = last[AW-1:0];
            if (present && ({1'b0, slot_rdata} != last)) begin
              state_next = ibh_pkg::S_FETCH;
            end
          end
          ibh_pkg::MODE_REKEY: begin
            if (present) begin
              state_next = ibh_pkg::S_FETCH;
            end
          end
          default: state_next = ibh_pkg::S_FINISH;
        endcase
      end
      ibh_pkg::S_FETCH: state_next = ibh_pkg::S_UP;
      ibh_pkg::S_UP: begin
        heap_raddr = parent;
        if (pos == '0) begin
          state_next = (moved || mode_r == ibh_pkg::MODE_INSERT) ?
                       ibh_pkg::S_PLACE : ibh_pkg::S_DOWN;
        end else begin
          state_next = ibh_pkg::S_UP_W;
        end
      end
      ibh_pkg::S_UP_W: begin
        if (heap_rdata.key <= cur.key) begin
          state_next = (moved || mode_r == ibh_pkg::MODE_INSERT) ?
                       ibh_pkg::S_PLACE : ibh_pkg::S_DOWN;
        end else begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          slot_we    = 1'b1;
          slot_waddr = heap_rdata.handle;
          state_next = ibh_pkg::S_UP;
        end
      end
      ibh_pkg::S_DOWN: begin
        heap_raddr = c_left[AW-1:0];
        state_next = (c_left >= occ) ? ibh_pkg::S_PLACE : ibh_pkg::S_DN_L;
      end
      ibh_pkg::S_DN_L: begin
        heap_raddr = c_right[AW-1:0];
        state_next = (c_right < occ) ? ibh_pkg::S_DN_R : ibh_pkg::S_DN_CMP;
      end
      ibh_pkg::S_DN_R: state_next = ibh_pkg::S_DN_CMP;
      ibh_pkg::S_DN_CMP: begin
        if (cur.key <= child.key) begin
          state_next = ibh_pkg::S_PLACE;
        end else begin
          heap_we    = 1'b1;
          heap_wdata = child;
          slot_we    = 1'b1;
          slot_waddr = child.handle;
          state_next = ibh_pkg::S_DOWN;
        end
      end
      ibh_pkg::S_PLACE: begin
        heap_we    = 1'b1;
        slot_we    = 1'b1;
        state_next = ibh_pkg::S_FINISH;
      end
      ibh_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = ibh_pkg::S_IDLE;
        end
      end
      default: state_next = ibh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ibh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= '0;
      present_bits <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (slot_we) begin
        present_bits[slot_waddr] <= 1'b1;
      end
      if (state == ibh_pkg::S_LOOK) begin
        if (mode_r == ibh_pkg::MODE_INSERT && !present && !occ[CW-1]) begin
          occ <= occ + CW'(1);
        end
        if (mode_r == ibh_pkg::MODE_REMOVE && present) begin
          occ <= last;
          present_bits[h_r] <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ibh_pkg::S_IDLE: begin
        mode_r     <= req.mode;
        key_r      <= req.key;
        h_r        <= req.handle;
        position_r <= req.position;
        moved      <= 1'b0;
      end
      ibh_pkg::S_LOOK: begin
        case (mode_r)
          ibh_pkg::MODE_INSERT: begin
            pos     <= occ[AW-1:0];
            cur     <= '{key: key_r, handle: h_r};
            found_r <= '0;
            if (present) begin
              status_r <= ibh_pkg::ST_DUP;
            end else if (occ[CW-1]) begin
              status_r <= ibh_pkg::ST_FULL;
            end else begin
              status_r <= ibh_pkg::ST_OK;
            end
          end
          ibh_pkg::MODE_READ: begin
            pos <= slot_rdata;
            if ({1'b0, position_r} >= occ) begin
              status_r <= ibh_pkg::ST_ABSENT;
              found_r  <= '0;
            end else begin
              status_r <= ibh_pkg::ST_OK;
              found_r  <= heap_rdata;
            end
          end
          default: begin
            pos     <= slot_rdata;
            found_r <= '0;
            if (!present) begin
              status_r <= ibh_pkg::ST_ABSENT;
            end else begin
              status_r <= ibh_pkg::ST_OK;
            end
          end
        endcase
      end
      ibh_pkg::S_FETCH: begin
        if (mode_r == ibh_pkg::MODE_REKEY) begin
          cur <= '{key: key_r, handle: heap_rdata.handle};
        end else begin
          cur <= heap_rdata;
        end
      end
      ibh_pkg::S_UP_W: begin
        if (heap_rdata.key > cur.key) begin
          pos   <= parent;
          moved <= 1'b1;
        end
      end
      ibh_pkg::S_DN_L: begin
        child <= heap_rdata;
        cpos  <= c_left[AW-1:0];
      end
      ibh_pkg::S_DN_R: begin
        if (heap_rdata.key <= child.key) begin
          child <= heap_rdata;
          cpos  <= c_right[AW-1:0];
        end
      end
      ibh_pkg::S_DN_CMP: begin
        if (cur.key > child.key) begin
          pos <= cpos;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      rsp.status       <= status_r;
      rsp.found_key    <= found_r.key;
      rsp.found_handle <= found_r.handle;
      rsp.entry_count  <= occ;
    end
  end

  assign rsp.valid = out_valid;
endmodule

>>> rtl/ibh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ibh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> bench/indexed_binary_min_heap_unit_tb.sv
// Testbench for the indexed binary min-heap unit: directed table, then random
// insert/remove/rekey/read traffic checked against a behavioral heap model.
// Depends on ibh_pkg, ibh_if and the unit's RTL.
module indexed_binary_min_heap_unit_tb;
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_key;
    logic [7:0]  found_handle;
    logic [8:0]  entry_count;
  } heap_rsp_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [7:0]  handle;
    logic [7:0]  position;
    bit          typed;
    heap_rsp_t   rsp;
  } heap_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ibh_req_if req ();
  ibh_rsp_if rsp ();

  indexed_binary_min_heap_unit DUT (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [31:0] mdl_keys [256];
  logic [7:0]  mdl_handles [256];
  logic [8:0]  mdl_slot [256];
  int          mdl_count;

  heap_rsp_t   expected_rsps [$];
  heap_rsp_t   typed_rsps [$];
  bit          typed_flags [$];
  int          mismatches;
  int          received;
  bit          stim_done;
  bit          hold_off;
  int          cycles;
  int          rx_wait = 0;

  function automatic void mdl_place(int p, logic [31:0] k, logic [7:0] h);
    mdl_keys[p] = k;
    mdl_handles[p] = h;
    mdl_slot[h] = {1'b1, p[7:0]};
  endfunction

  function automatic bit mdl_sift_up(int p);
    logic [31:0] k;
    logic [7:0]  h;
    bit          moved;
    int          par;
    k = mdl_keys[p];
    h = mdl_handles[p];
    moved = 0;
    while (p > 0) begin
      par = (p - 1) >> 1;
      if (mdl_keys[par] <= k) break;
      mdl_place(p, mdl_keys[par], mdl_handles[par]);
      p = par;
      moved = 1;
    end
    mdl_place(p, k, h);
    return moved;
  endfunction

  function automatic void mdl_sift_down(int p);
    logic [31:0] k;
    logic [7:0]  h;
    int          c;
    k = mdl_keys[p];
    h = mdl_handles[p];
    while (p < mdl_count) begin
      c = 2 * p + 1;
      if (c >= mdl_count) break;
      if (c + 1 < mdl_count && mdl_keys[c + 1] <= mdl_keys[c]) c = c + 1;
      if (k <= mdl_keys[c]) break;
      mdl_place(p, mdl_keys[c], mdl_handles[c]);
      p = c;
    end
    mdl_place(p, k, h);
  endfunction

  function automatic heap_rsp_t heap_predict(logic [1:0] mode, logic [31:0] key,
                                             logic [7:0] h, logic [7:0] position);
    heap_rsp_t r;
    bit        present;
    int        p;
    int        last;
    r = '0;
    present = mdl_slot[h][8] && (int'(mdl_slot[h][7:0]) < mdl_count);
    p = int'(mdl_slot[h][7:0]);
    case (mode)
      ibh_pkg::MODE_INSERT: begin
        if (present) r.status = ibh_pkg::ST_DUP;
        else if (mdl_count >= ibh_pkg::CAPACITY) r.status = ibh_pkg::ST_FULL;
        else begin
          mdl_count++;
          mdl_place(mdl_count - 1, key, h);
          void'(mdl_sift_up(mdl_count - 1));
        end
      end
      ibh_pkg::MODE_REMOVE: begin
        if (!present) r.status = ibh_pkg::ST_ABSENT;
        else begin
          last = mdl_count - 1;
          mdl_slot[h] = '0;
          mdl_count = last;
          if (p != last) begin
            mdl_place(p, mdl_keys[last], mdl_handles[last]);
            if (!mdl_sift_up(p)) mdl_sift_down(p);
          end
        end
      end
      ibh_pkg::MODE_REKEY: begin
        if (!present) r.status = ibh_pkg::ST_ABSENT;
        else begin
          mdl_keys[p] = key;
          if (!mdl_sift_up(p)) mdl_sift_down(p);
        end
      end
      default: begin
        if (int'(position) >= mdl_count) r.status = ibh_pkg::ST_ABSENT;
        else begin
          r.found_key = mdl_keys[position];
          r.found_handle = mdl_handles[position];
        end
      end
    endcase
    r.entry_count = 9'(mdl_count);
    return r;
  endfunction

  task automatic send_item(logic [1:0] mode, logic [31:0] key, logic [7:0] h,
                           logic [7:0] position, bit typed, heap_rsp_t typed_rsp);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.key <= key;
    req.handle <= h;
    req.position <= position;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_rsps.push_back(heap_predict(mode, key, h, position));
    typed_rsps.push_back(typed_rsp);
    typed_flags.push_back(typed);
  endtask

  function automatic heap_rsp_t mk(logic [1:0] s, logic [31:0] k, logic [7:0] h, int n);
    heap_rsp_t r;
    r.status = s;
    r.found_key = k;
    r.found_handle = h;
    r.entry_count = 9'(n);
    return r;
  endfunction

  heap_row_t directed [$];

  task automatic add_row(logic [1:0] m, logic [31:0] k, logic [7:0] h, logic [7:0] p,
                         bit t, heap_rsp_t r);
    heap_row_t row;
    row.mode = m;
    row.key = k;
    row.handle = h;
    row.position = p;
    row.typed = t;
    row.rsp = r;
    directed.push_back(row);
  endtask

  initial begin
    logic [1:0]  m;
    logic [7:0]  h;
    int          pick;
    req.valid = 1'b0;
    req.mode = ibh_pkg::MODE_READ;
    req.key = '0;
    req.handle = '0;
    req.position = '0;
    mdl_count = 0;
    foreach (mdl_slot[i]) mdl_slot[i] = '0;
    foreach (mdl_keys[i]) mdl_keys[i] = '0;
    foreach (mdl_handles[i]) mdl_handles[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(ibh_pkg::MODE_READ,   0, 0, 0, 1, mk(ibh_pkg::ST_ABSENT, 0, 0, 0));
    add_row(ibh_pkg::MODE_REMOVE, 0, 8'hff, 0, 1, mk(ibh_pkg::ST_ABSENT, 0, 0, 0));
    add_row(ibh_pkg::MODE_REKEY,  5, 8'h00, 0, 1, mk(ibh_pkg::ST_ABSENT, 0, 0, 0));
    add_row(ibh_pkg::MODE_INSERT, 32'hffffffff, 8'hff, 0, 1, mk(ibh_pkg::ST_OK, 0, 0, 1));
    add_row(ibh_pkg::MODE_READ,   0, 0, 0, 1,
            mk(ibh_pkg::ST_OK, 32'hffffffff, 8'hff, 1));
    add_row(ibh_pkg::MODE_INSERT, 0, 8'hff, 0, 1, mk(ibh_pkg::ST_DUP, 0, 0, 1));
    add_row(ibh_pkg::MODE_INSERT, 0, 8'h00, 0, 1, mk(ibh_pkg::ST_OK, 0, 0, 2));
    add_row(ibh_pkg::MODE_READ,   0, 0, 0, 1, mk(ibh_pkg::ST_OK, 0, 8'h00, 2));
    add_row(ibh_pkg::MODE_READ,   0, 0, 8'hff, 1, mk(ibh_pkg::ST_ABSENT, 0, 0, 2));
    add_row(ibh_pkg::MODE_INSERT, 0, 8'h55, 0, 0, '0);
    add_row(ibh_pkg::MODE_INSERT, 7, 8'haa, 0, 0, '0);
    add_row(ibh_pkg::MODE_INSERT, 7, 8'h0f, 0, 0, '0);
    add_row(ibh_pkg::MODE_REKEY,  32'hffffffff, 8'h00, 0, 0, '0);
    add_row(ibh_pkg::MODE_REKEY,  3, 8'hff, 0, 0, '0);
    add_row(ibh_pkg::MODE_READ,   0, 0, 1, 0, '0);
    add_row(ibh_pkg::MODE_REMOVE, 0, 8'h55, 0, 0, '0);
    add_row(ibh_pkg::MODE_REMOVE, 0, 8'h0f, 0, 0, '0);
    add_row(ibh_pkg::MODE_READ,   0, 0, 2, 0, '0);
    foreach (directed[i])
      send_item(directed[i].mode, directed[i].key, directed[i].handle,
                directed[i].position, directed[i].typed, directed[i].rsp);

    // fill to capacity, read the last position, then rekey and drain partly
    for (int i = 0; i < 256; i++)
      send_item(ibh_pkg::MODE_INSERT, $urandom_range(0, 40), i[7:0], 0, 0, '0);
    send_item(ibh_pkg::MODE_READ, 0, 0, 8'hff, 0, '0);
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++)
      send_item(ibh_pkg::MODE_REKEY, $urandom, 8'($urandom), 0, 0, '0);
    for (int i = 0; i < 150; i++)
      send_item(ibh_pkg::MODE_REMOVE, 0, 8'($urandom), 0, 0, '0);

    for (int i = 0; i < 600; i++) begin
      pick = $urandom_range(0, 99);
      h = (mdl_count > 0 && pick < 80) ? mdl_handles[$urandom_range(0, mdl_count - 1)]
                                       : 8'($urandom);
      m = (pick < 35) ? ibh_pkg::MODE_INSERT : (pick < 55) ? ibh_pkg::MODE_REMOVE :
          (pick < 80) ? ibh_pkg::MODE_REKEY : ibh_pkg::MODE_READ;
      if (m == ibh_pkg::MODE_INSERT && pick < 30) h = 8'($urandom);
      send_item(m, ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom,
                h, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                   : 8'($urandom_range(0, mdl_count > 0 ? mdl_count - 1 : 0)), 0, '0);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    hold_off = 1'b0;
    rsp.ready = 1'b0;
    wait (hold_off);
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || hold_off) begin
      rsp.ready <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      rx_wait = $urandom_range(0, 5);
      rsp.ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      rsp.ready <= (rx_wait == 0);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    heap_rsp_t got;
    heap_rsp_t want;
    bit        typed;
    heap_rsp_t tr;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.found_key, rsp.found_handle, rsp.entry_count};
      received++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %0d: %h", received, got);
      end else begin
        want = expected_rsps.pop_front();
        typed = typed_flags.pop_front();
        tr = typed_rsps.pop_front();
        if (got !== want || (typed && got !== tr)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("transfer %0d: expected st=%0d key=%h h=%h n=%0d got st=%0d key=%h h=%h n=%0d",
                     received, want.status, want.found_key, want.found_handle,
                     want.entry_count, got.status, got.found_key, got.found_handle,
                     got.entry_count);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    stim_done = 1'b0;
    mismatches = 0;
    received = 0;
    while (!(stim_done && expected_rsps.size() == 0) && cycles < 400000) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= 400000) begin
      $display("** indexed_binary_min_heap_unit: FAILED **");
    end else begin
      repeat (60) @(posedge clk);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
        $display("** indexed_binary_min_heap_unit: PASSED **");
      end else begin
        $display("** indexed_binary_min_heap_unit: FAILED **");
      end
    end
    $finish;
  end
endmodule
